// File: hw/rtl/imt_pkg.sv
`timescale 1ns / 1ps
package imt_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int KEY_W_DEF = 32;
  localparam int VAL_W_DEF = 8;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;

  localparam logic [OP_W-1:0] OP_ASSIGN = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] STS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLAN,
    ST_SHIFT,
    ST_WRITE,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_SHR,
    CM_SHL,
    CM_LOAD,
    CM_CLEAR
  } cell_mode_t;

  typedef struct packed {
    logic vld;
    logic lt_lo;
    logic le_lo;
    logic lt_hi;
    logic le_hi;
    logic eq_hi;
  } cell_flags_t;

endpackage

// File: hw/rtl/imt_cell.sv
`timescale 1ns / 1ps
module imt_cell #(
  parameter int KEY_WIDTH   = imt_pkg::KEY_W_DEF,
  parameter int VALUE_WIDTH = imt_pkg::VAL_W_DEF,
  parameter int IDX_WIDTH   = 8,
  parameter int IDX         = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  imt_pkg::cell_mode_t     mode,
  input  logic [IDX_WIDTH-1:0]    s_idx,
  input  logic [IDX_WIDTH-1:0]    t_idx,
  input  logic [IDX_WIDTH-1:0]    wa_idx,
  input  logic [IDX_WIDTH-1:0]    wb_idx,
  input  logic [IDX_WIDTH-1:0]    count,
  input  logic                    wa_en,
  input  logic                    wb_en,
  input  logic [KEY_WIDTH-1:0]    lo,
  input  logic [KEY_WIDTH-1:0]    hi,
  input  logic [VALUE_WIDTH-1:0]  wa_val,
  input  logic [VALUE_WIDTH-1:0]  wb_val,
  input  logic [VALUE_WIDTH-1:0]  clr_val,
  input  logic [KEY_WIDTH-1:0]    left_key,
  input  logic [VALUE_WIDTH-1:0]  left_val,
  input  logic [KEY_WIDTH-1:0]    right_key,
  input  logic [VALUE_WIDTH-1:0]  right_val,
  output logic [KEY_WIDTH-1:0]    key_o,
  output logic [VALUE_WIDTH-1:0]  val_o,
  output imt_pkg::cell_flags_t    flags_o
);
  import imt_pkg::*;

  localparam logic [IDX_WIDTH-1:0] MY_IDX = IDX_WIDTH'(IDX);

  logic [KEY_WIDTH-1:0]   key_r, key_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic                   vld;

  always_comb begin
    key_nxt = key_r;
    val_nxt = val_r;
    case (mode)
      CM_SHR: begin
        if (MY_IDX > s_idx) begin
          key_nxt = left_key;
          val_nxt = left_val;
        end
      end
      CM_SHL: begin
        if (MY_IDX >= t_idx) begin
          key_nxt = right_key;
          val_nxt = right_val;
        end
      end
      CM_LOAD: begin
        if (wa_en && MY_IDX == wa_idx) begin
          key_nxt = lo;
          val_nxt = wa_val;
        end else if (wb_en && MY_IDX == wb_idx) begin
          key_nxt = hi;
          val_nxt = wb_val;
        end
      end
      CM_CLEAR: begin
        if (MY_IDX == '0) begin
          key_nxt = '0;
          val_nxt = clr_val;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n && IDX == 0) begin
      key_r <= '0;
      val_r <= '0;
    end else begin
      key_r <= key_nxt;
      val_r <= val_nxt;
    end
  end

  assign vld           = MY_IDX < count;
  assign flags_o.vld   = vld;
  assign flags_o.lt_lo = vld && (key_r < lo);
  assign flags_o.le_lo = vld && (key_r <= lo);
  assign flags_o.lt_hi = vld && (key_r < hi);
  assign flags_o.le_hi = vld && (key_r <= hi);
  assign flags_o.eq_hi = vld && (key_r == hi);
  assign key_o         = key_r;
  assign val_o         = val_r;

endmodule

// File: hw/rtl/interval_map_table_core.sv
`timescale 1ns / 1ps
// channel | direction | handshake              | payload
// in_     | input     | in_valid / in_ready    | op, key_low, key_high, value
// out_    | output    | out_valid / out_ready  | read_value, status, entries_used
// cfg_    | input     | cfg_wr_en              | cfg_wr_data (value loaded by clear)
// one item at a time; lookup, clear or empty assign: scan, out;
// refused assign: scan, plan, out; assign: scan, plan, shift, write, out;
// shift moves entries above the interval one cell per cycle (up to DEPTH)
// rst_n synchronous: table holds one entry, key 0, value 0
// a result waiting on out_ready does not block the next input transfer
module interval_map_table_core #(
  parameter int DEPTH       = imt_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH   = imt_pkg::KEY_W_DEF,
  parameter int VALUE_WIDTH = imt_pkg::VAL_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [VALUE_WIDTH-1:0]        cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [imt_pkg::OP_W-1:0]      in_op,
  input  logic [KEY_WIDTH-1:0]          in_key_low,
  input  logic [KEY_WIDTH-1:0]          in_key_high,
  input  logic [VALUE_WIDTH-1:0]        in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [VALUE_WIDTH-1:0]        out_read_value,
  output logic [imt_pkg::STATUS_W-1:0]  out_status,
  output logic [$clog2(DEPTH+1)-1:0]    out_entries_used
);
  import imt_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = CW + 1;

  state_t                 state_r, state_nxt;
  logic [OP_W-1:0]        op_r, op_nxt;
  logic [KEY_WIDTH-1:0]   lo_r, lo_nxt, hi_r, hi_nxt;
  logic [VALUE_WIDTH-1:0] v_r, v_nxt, init_r;
  logic [CW-1:0]          count_r, count_nxt, p_r, p_nxt, q_r, q_nxt;
  logic [VALUE_WIDTH-1:0] prev_val_r, prev_val_nxt, end_val_r, end_val_nxt;
  logic [VALUE_WIDTH-1:0] qval_r, qval_nxt;
  logic                   hi_pres_r, hi_pres_nxt, lk_r, lk_nxt, hk_r, hk_nxt;
  logic [PW-1:0]          s_r, s_nxt, t_r, t_nxt, nc_r, nc_nxt;
  logic [VALUE_WIDTH-1:0] res_val_r, res_val_nxt;
  logic [STATUS_W-1:0]    res_sts_r, res_sts_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [VALUE_WIDTH-1:0] out_val_r, out_val_nxt;
  logic [STATUS_W-1:0]    out_sts_r, out_sts_nxt;
  logic [CW-1:0]          out_cnt_r, out_cnt_nxt;

  cell_mode_t             cmode;
  logic [KEY_WIDTH-1:0]   key_w [DEPTH];
  logic [VALUE_WIDTH-1:0] val_w [DEPTH];
  cell_flags_t            flg_w [DEPTH];
  logic [DEPTH:0]         lt_lo_v, le_lo_v, lt_hi_v, le_hi_v;
  logic [DEPTH-1:0]       eq_hi_v, hi_first_v;

  logic [CW-1:0]          p_c, q_c;
  logic [VALUE_WIDTH-1:0] prev_c, endv_c, look_c, qval_c;
  logic                   hipres_c;
  logic                   lk_c, hk_c, bd_c;
  logic [PW-1:0]          nc_c, s_c, t_c;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    imt_cell #(
      .KEY_WIDTH  (KEY_WIDTH),
      .VALUE_WIDTH(VALUE_WIDTH),
      .IDX_WIDTH  (PW),
      .IDX        (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .mode     (cmode),
      .s_idx    (s_r),
      .t_idx    (t_r),
      .wa_idx   (PW'(p_r)),
      .wb_idx   (PW'(p_r) + PW'(lk_r)),
      .count    (PW'(count_r)),
      .wa_en    (lk_r),
      .wb_en    (hk_r),
      .lo       (lo_r),
      .hi       (hi_r),
      .wa_val   (v_r),
      .wb_val   (end_val_r),
      .clr_val  (init_r),
      .left_key (key_w[(g == 0) ? 0 : g - 1]),
      .left_val (val_w[(g == 0) ? 0 : g - 1]),
      .right_key(key_w[(g == DEPTH - 1) ? g : g + 1]),
      .right_val(val_w[(g == DEPTH - 1) ? g : g + 1]),
      .key_o    (key_w[g]),
      .val_o    (val_w[g]),
      .flags_o  (flg_w[g])
    );
    assign lt_lo_v[g] = flg_w[g].lt_lo;
    assign le_lo_v[g] = flg_w[g].le_lo;
    assign lt_hi_v[g] = flg_w[g].lt_hi;
    assign le_hi_v[g] = flg_w[g].le_hi;
    assign eq_hi_v[g] = flg_w[g].eq_hi;
    if (g == 0) begin : g_first
      assign hi_first_v[g] = flg_w[g].vld && !flg_w[g].lt_hi;
    end else begin : g_rest
      assign hi_first_v[g] = flg_w[g].vld && !flg_w[g].lt_hi && lt_hi_v[g-1];
    end
  end
  assign lt_lo_v[DEPTH] = 1'b0;
  assign le_lo_v[DEPTH] = 1'b0;
  assign lt_hi_v[DEPTH] = 1'b0;
  assign le_hi_v[DEPTH] = 1'b0;

  // prefix boundaries of the sorted table, one-hot
  always_comb begin
    p_c      = '0;
    q_c      = '0;
    prev_c   = '0;
    endv_c   = '0;
    look_c   = '0;
    qval_c   = '0;
    hipres_c = |eq_hi_v;
    for (int i = 0; i < DEPTH; i++) begin
      if (lt_lo_v[i] && !lt_lo_v[i+1]) begin
        p_c    = p_c | CW'(i + 1);
        prev_c = prev_c | val_w[i];
      end
      if (lt_hi_v[i] && !lt_hi_v[i+1]) begin
        q_c = q_c | CW'(i + 1);
      end
      if (le_hi_v[i] && !le_hi_v[i+1]) begin
        endv_c = endv_c | val_w[i];
      end
      if (le_lo_v[i] && !le_lo_v[i+1]) begin
        look_c = look_c | val_w[i];
      end
      if (hi_first_v[i]) begin
        qval_c = qval_c | val_w[i];
      end
    end
  end

  // merges happen only where the new interval meets its neighbors
  always_comb begin
    lk_c = (p_r == '0) || (prev_val_r != v_r);
    hk_c = !hi_pres_r && (end_val_r != v_r);
    bd_c = hi_pres_r && (qval_r == v_r);
    nc_c = PW'(p_r) + PW'(lk_c) + PW'(hk_c) + PW'(count_r) - PW'(q_r) - PW'(bd_c);
    s_c  = PW'(q_r) + PW'(bd_c);
    t_c  = PW'(p_r) + PW'(lk_c) + PW'(hk_c);
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    v_nxt         = v_r;
    count_nxt     = count_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    prev_val_nxt  = prev_val_r;
    end_val_nxt   = end_val_r;
    qval_nxt      = qval_r;
    hi_pres_nxt   = hi_pres_r;
    lk_nxt        = lk_r;
    hk_nxt        = hk_r;
    s_nxt         = s_r;
    t_nxt         = t_r;
    nc_nxt        = nc_r;
    res_val_nxt   = res_val_r;
    res_sts_nxt   = res_sts_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_val_nxt   = out_val_r;
    out_sts_nxt   = out_sts_r;
    out_cnt_nxt   = out_cnt_r;
    cmode         = CM_HOLD;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt    = in_op;
          lo_nxt    = in_key_low;
          hi_nxt    = in_key_high;
          v_nxt     = in_value;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        res_val_nxt = '0;
        res_sts_nxt = STS_DONE;
        state_nxt   = ST_OUT;
        case (op_r)
          OP_LOOKUP: res_val_nxt = look_c;
          OP_CLEAR: begin
            cmode     = CM_CLEAR;
            count_nxt = CW'(1);
          end
          OP_ASSIGN: begin
            if (lo_r >= hi_r) begin
              res_sts_nxt = STS_EMPTY;
            end else begin
              p_nxt        = p_c;
              q_nxt        = q_c;
              prev_val_nxt = prev_c;
              end_val_nxt  = endv_c;
              qval_nxt     = qval_c;
              hi_pres_nxt  = hipres_c;
              state_nxt    = ST_PLAN;
            end
          end
          default: begin
          end
        endcase
      end
      ST_PLAN: begin
        lk_nxt = lk_c;
        hk_nxt = hk_c;
        s_nxt  = s_c;
        t_nxt  = t_c;
        nc_nxt = nc_c;
        if (nc_c > PW'(DEPTH)) begin
          res_sts_nxt = STS_FULL;
          state_nxt   = ST_OUT;
        end else begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (s_r == t_r) begin
          state_nxt = ST_WRITE;
        end else if (t_r > s_r) begin
          cmode = CM_SHR;
          s_nxt = s_r + PW'(1);
        end else begin
          cmode = CM_SHL;
          s_nxt = s_r - PW'(1);
        end
      end
      ST_WRITE: begin
        cmode       = CM_LOAD;
        count_nxt   = nc_r[CW-1:0];
        res_sts_nxt = STS_DONE;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_sts_nxt   = res_sts_r;
          out_cnt_nxt   = count_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= CW'(1);
      out_valid_r <= 1'b0;
      init_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        init_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    v_r        <= v_nxt;
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    prev_val_r <= prev_val_nxt;
    end_val_r  <= end_val_nxt;
    qval_r     <= qval_nxt;
    hi_pres_r  <= hi_pres_nxt;
    lk_r       <= lk_nxt;
    hk_r       <= hk_nxt;
    s_r        <= s_nxt;
    t_r        <= t_nxt;
    nc_r       <= nc_nxt;
    res_val_r  <= res_val_nxt;
    res_sts_r  <= res_sts_nxt;
    out_val_r  <= out_val_nxt;
    out_sts_r  <= out_sts_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_read_value   = out_val_r;
  assign out_status       = out_sts_r;
  assign out_entries_used = out_cnt_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 && count_r <= CW'(DEPTH))
    else $error("entry count out of range");

  a_entry0_key: assert property (@(posedge clk) disable iff (!rst_n)
    key_w[0] == '0)
    else $error("entry 0 key not zero");

  a_shift_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SHIFT && s_r == t_r |=> state_r == ST_WRITE)
    else $error("shift did not finish");

  a_transfer_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_SCAN)
    else $error("transfer not followed by scan");

endmodule
